[hw/rtl/assert_macros.svh]
// assertion macros included by the peer table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pta_pkg.sv]
// types, codes and sizes shared by the peer table files
package pta_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] FN_ADD     = 3'd0;
    localparam logic [2:0] FN_SWEEP   = 3'd1;
    localparam logic [2:0] FN_TOUCH   = 3'd2;
    localparam logic [2:0] FN_SETCONN = 3'd3;
    localparam logic [2:0] FN_FIND    = 3'd4;

    localparam logic [3:0] OC_UPDATED    = 4'd0;
    localparam logic [3:0] OC_ADDED      = 4'd1;
    localparam logic [3:0] OC_FULL       = 4'd2;
    localparam logic [3:0] OC_TOUCHED    = 4'd3;
    localparam logic [3:0] OC_FLAG_SET   = 4'd4;
    localparam logic [3:0] OC_NOT_FOUND  = 4'd5;
    localparam logic [3:0] OC_FOUND      = 4'd6;
    localparam logic [3:0] OC_STALE      = 4'd7;
    localparam logic [3:0] OC_SWEEP_DONE = 4'd8;

    typedef struct packed {
        logic [55:0] uuid_high;
        logic [63:0] uuid_low;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] seen;
        logic        conn;
    } entry_t;

    typedef struct packed {
        logic [3:0] outcome;
        entry_t     ent;
        logic [3:0] entry_count;
        logic [3:0] removed_count;
        logic       last;
    } res_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } ram_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_APPLY,
        ST_SWP_RD,
        ST_SWP_CHK,
        ST_SWP_NEXT,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_SUMMARY,
        ST_EMIT
    } state_t;

endpackage

[hw/rtl/pta_ram.sv]
// entry memory, one write and one registered read per cycle
module pta_ram
    import pta_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    input  entry_t   wr_data,
    output entry_t   rd_data
);

    entry_t mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

[hw/rtl/pta_engine.sv]
// sequencer for lookup, update, append and age sweep over the entry memory
module pta_engine
    import pta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  in_func,
    input  entry_t      in_ent,
    input  logic [31:0] timeout_ms,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    output ram_req_t    ram_req,
    output entry_t      ram_wdata,
    input  entry_t      ram_rdata
);

    state_t st_reg, st_next;
    logic [2:0] func_reg, func_next;
    entry_t item_reg, item_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic [MAX_ENTRIES-1:0] stale_reg, stale_next;
    logic hit_reg, hit_next;
    res_t res_reg, res_next;

    logic id_match;
    logic is_stale;
    logic scan_end;
    logic [31:0] age;

    assign id_match = (ram_rdata.uuid_high == item_reg.uuid_high) &&
                      (ram_rdata.uuid_low == item_reg.uuid_low);
    assign age      = item_reg.seen - ram_rdata.seen;
    assign is_stale = age > timeout_ms;
    assign scan_end = (idx_reg + CNT_W'(1)) == cnt_reg;

    assign in_ready  = (st_reg == ST_IDLE);
    assign res_valid = (st_reg == ST_EMIT);
    assign res       = res_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_func == FN_SWEEP) begin
                        st_next = (cnt_reg == '0) ? ST_SUMMARY : ST_SWP_RD;
                    end else if (in_func inside {FN_ADD, FN_TOUCH, FN_SETCONN, FN_FIND}) begin
                        st_next = (cnt_reg == '0) ? ST_APPLY : ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: st_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (id_match || scan_end) begin
                    st_next = ST_APPLY;
                end else begin
                    st_next = ST_SCAN_RD;
                end
            end
            ST_APPLY: st_next = ST_EMIT;
            ST_SWP_RD: st_next = ST_SWP_CHK;
            ST_SWP_CHK: st_next = is_stale ? ST_EMIT : ST_SWP_NEXT;
            ST_SWP_NEXT: begin
                if (idx_reg != '0) begin
                    st_next = ST_SWP_RD;
                end else if (removed_reg == '0) begin
                    st_next = ST_SUMMARY;
                end else begin
                    st_next = ST_CMP_RD;
                end
            end
            ST_CMP_RD: st_next = ST_CMP_WR;
            ST_CMP_WR: st_next = scan_end ? ST_SUMMARY : ST_CMP_RD;
            ST_SUMMARY: st_next = ST_EMIT;
            ST_EMIT: begin
                if (res_ready) begin
                    st_next = res_reg.last ? ST_IDLE : ST_SWP_NEXT;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        entry_t e;
        e            = ram_rdata;
        func_next    = func_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        removed_next = removed_reg;
        wr_idx_next  = wr_idx_reg;
        stale_next   = stale_reg;
        hit_next     = hit_reg;
        res_next     = res_reg;
        ram_req      = '0;
        ram_wdata    = ram_rdata;
        case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    func_next    = in_func;
                    item_next    = in_ent;
                    hit_next     = 1'b0;
                    removed_next = '0;
                    stale_next   = '0;
                    idx_next     = (in_func == FN_SWEEP) ? cnt_reg - CNT_W'(1) : '0;
                end
            end
            ST_SCAN_RD, ST_SWP_RD, ST_CMP_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_reg[IDX_W-1:0];
            end
            ST_SCAN_CHK: begin
                if (id_match) begin
                    hit_next = 1'b1;
                end else if (!scan_end) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_APPLY: begin
                res_next.removed_count = '0;
                res_next.last          = 1'b1;
                res_next.entry_count   = 4'(cnt_reg);
                ram_req.wr_addr        = idx_reg[IDX_W-1:0];
                if (func_reg == FN_ADD) begin
                    if (hit_reg) begin
                        e.ip             = item_reg.ip;
                        e.port           = item_reg.port;
                        e.seen           = item_reg.seen;
                        ram_req.wr_en    = 1'b1;
                        res_next.outcome = OC_UPDATED;
                    end else if (cnt_reg < CNT_W'(MAX_ENTRIES)) begin
                        e                    = item_reg;
                        e.conn               = 1'b0;
                        ram_req.wr_en        = 1'b1;
                        ram_req.wr_addr      = cnt_reg[IDX_W-1:0];
                        cnt_next             = cnt_reg + CNT_W'(1);
                        res_next.entry_count = 4'(cnt_reg + CNT_W'(1));
                        res_next.outcome     = OC_ADDED;
                    end else begin
                        e                = item_reg;
                        e.conn           = 1'b0;
                        res_next.outcome = OC_FULL;
                    end
                end else if (!hit_reg) begin
                    e                = '0;
                    e.uuid_high      = item_reg.uuid_high;
                    e.uuid_low       = item_reg.uuid_low;
                    res_next.outcome = OC_NOT_FOUND;
                end else if (func_reg == FN_TOUCH) begin
                    e.seen           = item_reg.seen;
                    ram_req.wr_en    = 1'b1;
                    res_next.outcome = OC_TOUCHED;
                end else if (func_reg == FN_SETCONN) begin
                    e.conn           = item_reg.conn;
                    ram_req.wr_en    = 1'b1;
                    res_next.outcome = OC_FLAG_SET;
                end else begin
                    res_next.outcome = OC_FOUND;
                end
                ram_wdata    = e;
                res_next.ent = e;
            end
            ST_SWP_CHK: begin
                if (is_stale) begin
                    stale_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    removed_next           = removed_reg + CNT_W'(1);
                    res_next.outcome       = OC_STALE;
                    res_next.ent           = ram_rdata;
                    res_next.entry_count   = 4'(cnt_reg - removed_reg - CNT_W'(1));
                    res_next.removed_count = '0;
                    res_next.last          = 1'b0;
                end
            end
            ST_SWP_NEXT: begin
                if (idx_reg != '0) begin
                    idx_next = idx_reg - CNT_W'(1);
                end else begin
                    wr_idx_next = '0;
                end
            end
            ST_CMP_WR: begin
                if (!stale_reg[idx_reg[IDX_W-1:0]]) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = wr_idx_reg[IDX_W-1:0];
                    wr_idx_next     = wr_idx_reg + CNT_W'(1);
                end
                if (!scan_end) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_SUMMARY: begin
                cnt_next               = cnt_reg - removed_reg;
                res_next.outcome       = OC_SWEEP_DONE;
                res_next.ent           = '0;
                res_next.entry_count   = 4'(cnt_reg - removed_reg);
                res_next.removed_count = 4'(removed_reg);
                res_next.last          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        removed_reg <= removed_next;
        wr_idx_reg  <= wr_idx_next;
        stale_reg   <= stale_next;
        hit_reg     <= hit_next;
        res_reg     <= res_next;
    end

endmodule

[hw/rtl/peer_table_with_aging.sv]
// peer table top level: ports, timeout register, output register, assertions
//
//  channel  | dir | tdata                        | tuser   | tlast
//  s_       | in  | peer identifier and address  | func    | -
//  m_       | out | entry, counts                | outcome | final word of item
//  cfg_     | in  | stale timeout, write only    | -       | -
//
// one word at a time; a lookup compares the stored entries in order up to a match
// an age sweep checks the entries from last to first and emits a word per removal;
// when anything is removed, a read and write pass then compacts the memory,
// and a summary word closes the item; the memory has one write and one read port
// reset empties the table and sets the timeout to 30000 ms
// a stalled m_ side holds the sequencer; s_tready stays low until the item is done
`include "assert_macros.svh"

module peer_table_with_aging
    import pta_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // uuid_high, uuid_low, ip_addr, port_num, now_ms, connected_in, zero pad
    input  logic [207:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_uuid_high, out_uuid_low, out_ip, out_port, out_last_seen, out_connected,
    // entry_count, removed_count, zero pad
    output logic [215:0] m_tdata,
    // outcome
    output logic [3:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    logic [31:0] timeout_reg;
    logic        m_tvalid_reg;
    res_t        m_res_reg;

    entry_t   in_ent;
    res_t     res;
    logic     res_valid;
    logic     res_ready;
    ram_req_t ram_req;
    entry_t   ram_wdata;
    entry_t   ram_rdata;

    assign in_ent.uuid_high = s_tdata[55:0];
    assign in_ent.uuid_low  = s_tdata[119:56];
    assign in_ent.ip        = s_tdata[151:120];
    assign in_ent.port      = s_tdata[167:152];
    assign in_ent.seen      = s_tdata[199:168];
    assign in_ent.conn      = s_tdata[200];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 32'd30000;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    pta_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_ent     (in_ent),
        .timeout_ms (timeout_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_req    (ram_req),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

    pta_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    // output word register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.outcome;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {7'd0, m_res_reg.removed_count, m_res_reg.entry_count,
                       m_res_reg.ent.conn, m_res_reg.ent.seen, m_res_reg.ent.port,
                       m_res_reg.ent.ip, m_res_reg.ent.uuid_low, m_res_reg.ent.uuid_high};

    `ASSERT_ALWAYS(a_out_clear_after_reset, aclk, !aresetn |=> !m_tvalid,
        "output valid after reset")

    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn,
        (s_tvalid && s_tready && (s_tuser == FN_ADD || s_tuser == FN_SWEEP ||
         s_tuser == FN_TOUCH || s_tuser == FN_SETCONN || s_tuser == FN_FIND))
        |=> !s_tready,
        "new word taken while an item is in progress")

    `ASSERT_CLK(a_summary_is_last, aclk, aresetn,
        (m_tvalid && m_tuser == OC_SWEEP_DONE) |-> m_tlast,
        "sweep summary without tlast")

    `ASSERT_CLK(a_removal_not_last, aclk, aresetn,
        (m_tvalid && m_tuser == OC_STALE) |-> (!m_tlast && m_tdata[208:205] == 4'd0),
        "removal report closes item or carries a count")

    `ASSERT_CLK(a_no_result_while_idle, aclk, aresetn,
        (s_tready && !m_tvalid) |=> (!m_tvalid || !$past(s_tvalid)
         || $past(s_tuser) == FN_ADD || $past(s_tuser) == FN_SWEEP
         || $past(s_tuser) == FN_TOUCH || $past(s_tuser) == FN_SETCONN
         || $past(s_tuser) == FN_FIND || !$past(s_tready)),
        "result word without an item")

endmodule
